### design/fmpd_pkg.sv
`timescale 1ns / 1ps

package fmpd_pkg;

  // width of the cordic x/y datapath: 16-bit input, pre-rotation and cordic gain
  localparam int unsigned XY_W = 20;
  localparam int unsigned Z_W = 32;
  localparam int unsigned ATAN_LEN = 24;

  localparam int unsigned SUM_W = 29;
  localparam int unsigned FREQ_W = 16;

  // longest block the running sum is sized for
  localparam longint BlockMax = 64'd8192;
  localparam longint SumLim = 64'd268435456;
  localparam longint SumHiRaw = BlockMax * 64'd32768 - 64'd1;
  localparam longint SumLoRaw = -(BlockMax * 64'd32768);
  localparam logic signed [SUM_W:0] SUM_HI =
      (SUM_W + 1)'((SumHiRaw > SumLim - 64'd1) ? SumLim - 64'd1 : SumHiRaw);
  localparam logic signed [SUM_W:0] SUM_LO =
      (SUM_W + 1)'((SumLoRaw < -SumLim) ? -SumLim : SumLoRaw);

  localparam logic [Z_W-1:0] Z_PLUS_HALF_PI = 32'h4000_0000;
  localparam logic [Z_W-1:0] Z_MINUS_HALF_PI = 32'hC000_0000;
  localparam logic [Z_W-1:0] Z_ROUND = 32'h0000_8000;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
  } cord_t;

  typedef struct packed {
    logic zero;
    logic last;
    logic mute;
    logic measure;
  } side_t;

  // atan(2^-k) / pi * 2^31
  function automatic logic [Z_W-1:0] atan_entry(input int unsigned k);
    logic [Z_W-1:0] v;
    unique case (k)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10680350;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/fmpd_pre.sv
`timescale 1ns / 1ps

module fmpd_pre (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic signed [15:0]        i_sample_i,
  input  logic signed [15:0]        q_sample_i,
  input  logic                      last_i,
  input  logic                      mute_i,
  input  logic                      measure_i,
  output logic                      valid_o,
  output fmpd_pkg::cord_t           cord_o,
  output fmpd_pkg::side_t           side_o
);

  logic            valid_q;
  fmpd_pkg::cord_t cord_d, cord_q;
  fmpd_pkg::side_t side_d, side_q;
  logic signed [fmpd_pkg::XY_W-1:0] xi, yi;

  assign xi = fmpd_pkg::XY_W'(i_sample_i);
  assign yi = fmpd_pkg::XY_W'(q_sample_i);

  // fold the left half plane onto the right one
  always_comb begin
    cord_d.x = xi;
    cord_d.y = yi;
    cord_d.z = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        cord_d.x = yi;
        cord_d.y = -xi;
        cord_d.z = fmpd_pkg::Z_PLUS_HALF_PI;
      end else begin
        cord_d.x = -yi;
        cord_d.y = xi;
        cord_d.z = fmpd_pkg::Z_MINUS_HALF_PI;
      end
    end
    side_d.zero    = (i_sample_i == '0) && (q_sample_i == '0);
    side_d.last    = last_i;
    side_d.mute    = mute_i;
    side_d.measure = measure_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cord_q <= cord_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;
  assign side_o  = side_q;

endmodule

### design/fmpd_cell.sv
`timescale 1ns / 1ps

module fmpd_cell #(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  fmpd_pkg::cord_t cord_i,
  input  fmpd_pkg::side_t side_i,
  output logic            valid_o,
  output fmpd_pkg::cord_t cord_o,
  output fmpd_pkg::side_t side_o
);

  logic            valid_q;
  fmpd_pkg::cord_t cord_d, cord_q;
  fmpd_pkg::side_t side_q;
  logic signed [fmpd_pkg::XY_W-1:0] dx, dy;
  logic [fmpd_pkg::Z_W-1:0] step;

  assign dx   = cord_i.y >>> K;
  assign dy   = cord_i.x >>> K;
  assign step = fmpd_pkg::atan_entry(K);

  // micro-rotation toward y = 0, y of zero counts as positive
  always_comb begin
    if (cord_i.y >= 0) begin
      cord_d.x = cord_i.x + dx;
      cord_d.y = cord_i.y - dy;
      cord_d.z = cord_i.z + step;
    end else begin
      cord_d.x = cord_i.x - dx;
      cord_d.y = cord_i.y + dy;
      cord_d.z = cord_i.z - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cord_q <= cord_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;
  assign side_o  = side_q;

endmodule

### design/fmpd_diff.sv
`timescale 1ns / 1ps

module fmpd_diff (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  fmpd_pkg::cord_t                     cord_i,
  input  fmpd_pkg::side_t                     side_i,
  output logic                                valid_o,
  output logic signed [fmpd_pkg::FREQ_W-1:0]  freq_o,
  output fmpd_pkg::side_t                     side_o
);

  logic                               valid_q;
  logic [fmpd_pkg::Z_W-1:0]           z_rnd;
  logic [fmpd_pkg::FREQ_W-1:0]        phase;
  logic [fmpd_pkg::FREQ_W-1:0]        last_phase_d, last_phase_q;
  logic signed [fmpd_pkg::FREQ_W-1:0] freq_d, freq_q;
  fmpd_pkg::side_t                    side_q;

  assign z_rnd = cord_i.z + fmpd_pkg::Z_ROUND;

  always_comb begin
    phase = side_i.zero ? '0 : z_rnd[fmpd_pkg::Z_W-1 -: fmpd_pkg::FREQ_W];
    if (side_i.mute) begin
      freq_d       = '0;
      last_phase_d = '0;
    end else begin
      // modulo 2^16 difference wraps into [-1, 1)
      freq_d       = phase - last_phase_q;
      last_phase_d = phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      last_phase_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        last_phase_q <= last_phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      freq_q <= freq_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign freq_o  = freq_q;
  assign side_o  = side_q;

endmodule

### design/fmpd_stats.sv
`timescale 1ns / 1ps

module fmpd_stats (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic signed [fmpd_pkg::FREQ_W-1:0]  freq_i,
  input  fmpd_pkg::side_t                     side_i,
  output logic                                out_valid_o,
  output logic signed [fmpd_pkg::FREQ_W-1:0]  freq_sample_o,
  output logic signed [fmpd_pkg::SUM_W-1:0]   block_sum_o,
  output logic [fmpd_pkg::FREQ_W-2:0]         peak_positive_o,
  output logic signed [fmpd_pkg::FREQ_W-1:0]  peak_negative_o,
  output logic                                stats_valid_o
);

  logic                               valid_q;
  logic signed [fmpd_pkg::SUM_W-1:0]  sum_q, sum_upd, sum_d;
  logic signed [fmpd_pkg::FREQ_W-1:0] max_q, max_upd, max_d;
  logic signed [fmpd_pkg::FREQ_W-1:0] min_q, min_upd, min_d;
  logic signed [fmpd_pkg::SUM_W:0]    sum_wide;
  logic                               rep;

  logic signed [fmpd_pkg::FREQ_W-1:0] freq_q, pneg_q;
  logic signed [fmpd_pkg::SUM_W-1:0]  bsum_q;
  logic [fmpd_pkg::FREQ_W-2:0]        ppos_q;
  logic                               sv_q;

  assign sum_wide = (fmpd_pkg::SUM_W + 1)'(sum_q) + (fmpd_pkg::SUM_W + 1)'(freq_i);
  assign rep      = side_i.last && side_i.measure;

  always_comb begin
    sum_upd = sum_q;
    max_upd = max_q;
    min_upd = min_q;
    if (side_i.measure) begin
      priority if (sum_wide > fmpd_pkg::SUM_HI) begin
        sum_upd = fmpd_pkg::SUM_HI[fmpd_pkg::SUM_W-1:0];
      end else if (sum_wide < fmpd_pkg::SUM_LO) begin
        sum_upd = fmpd_pkg::SUM_LO[fmpd_pkg::SUM_W-1:0];
      end else begin
        sum_upd = sum_wide[fmpd_pkg::SUM_W-1:0];
      end
      priority if (freq_i > max_q) begin
        max_upd = freq_i;
      end else if (freq_i < min_q) begin
        min_upd = freq_i;
      end else begin
        max_upd = max_q;
      end
    end
    // end of block clears the statistics whether reported or not
    sum_d = side_i.last ? '0 : sum_upd;
    max_d = side_i.last ? '0 : max_upd;
    min_d = side_i.last ? '0 : min_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        sum_q <= sum_d;
        max_q <= max_d;
        min_q <= min_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      freq_q <= freq_i;
      sv_q   <= rep;
      bsum_q <= rep ? sum_upd : '0;
      ppos_q <= rep ? max_upd[fmpd_pkg::FREQ_W-2:0] : '0;
      pneg_q <= rep ? min_upd : '0;
    end
  end

  assign out_valid_o     = valid_q;
  assign freq_sample_o   = freq_q;
  assign block_sum_o     = bsum_q;
  assign peak_positive_o = ppos_q;
  assign peak_negative_o = pneg_q;
  assign stats_valid_o   = sv_q;

endmodule

### design/fm_phase_discriminator.sv
`timescale 1ns / 1ps
// registered stages from input transaction to result valid, in order:
// input fold stage, one cordic cell per micro-rotation, phase difference, statistics
// throughput: one transaction per cycle; the whole cell chain advances together and
// holds only while a finished result waits at the output register
// reset: asynchronous, active low; clears stage valid bits, phase memory and statistics
module fm_phase_discriminator #(
  parameter int unsigned ANGLE_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] i_sample_i,
  input  logic signed [15:0] q_sample_i,
  input  logic               last_in_block_i,
  input  logic               mute_i,
  input  logic               measure_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] freq_sample_o,
  output logic signed [28:0] block_sum_o,
  output logic [14:0]        peak_positive_o,
  output logic signed [15:0] peak_negative_o,
  output logic               stats_valid_o
);

  logic                               adv;
  logic                               valid_s [ANGLE_STAGES+1];
  fmpd_pkg::cord_t                    cord_s  [ANGLE_STAGES+1];
  fmpd_pkg::side_t                    side_s  [ANGLE_STAGES+1];
  logic                               dvalid;
  logic signed [fmpd_pkg::FREQ_W-1:0] dfreq;
  fmpd_pkg::side_t                    dside;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  fmpd_pre u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .i_sample_i (i_sample_i),
    .q_sample_i (q_sample_i),
    .last_i     (last_in_block_i),
    .mute_i     (mute_i),
    .measure_i  (measure_i),
    .valid_o    (valid_s[0]),
    .cord_o     (cord_s[0]),
    .side_o     (side_s[0])
  );

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
    fmpd_cell #(
      .K (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[k]),
      .cord_i  (cord_s[k]),
      .side_i  (side_s[k]),
      .valid_o (valid_s[k+1]),
      .cord_o  (cord_s[k+1]),
      .side_o  (side_s[k+1])
    );
  end

  fmpd_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_s[ANGLE_STAGES]),
    .cord_i  (cord_s[ANGLE_STAGES]),
    .side_i  (side_s[ANGLE_STAGES]),
    .valid_o (dvalid),
    .freq_o  (dfreq),
    .side_o  (dside)
  );

  fmpd_stats u_stats (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (dvalid),
    .freq_i          (dfreq),
    .side_i          (dside),
    .out_valid_o     (out_valid_o),
    .freq_sample_o   (freq_sample_o),
    .block_sum_o     (block_sum_o),
    .peak_positive_o (peak_positive_o),
    .peak_negative_o (peak_negative_o),
    .stats_valid_o   (stats_valid_o)
  );

endmodule

### design/fmpd_checker.sv
`timescale 1ns / 1ps

module fmpd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] freq_sample_o,
  input logic signed [28:0] block_sum_o,
  input logic [14:0]        peak_positive_o,
  input logic signed [15:0] peak_negative_o,
  input logic               stats_valid_o
);

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // statistics fields are zero unless the block is reported
  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stats_valid_o) |->
      (block_sum_o == '0 && peak_positive_o == '0 && peak_negative_o == '0))
    else $error("statistics fields nonzero without stats_valid");

  a_peak_neg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_negative_o[15] || peak_negative_o == '0))
    else $error("negative peak above zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(freq_sample_o) && $stable(block_sum_o)))
    else $error("stalled result changed");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .freq_sample_o   (freq_sample_o),
  .block_sum_o     (block_sum_o),
  .peak_positive_o (peak_positive_o),
  .peak_negative_o (peak_negative_o),
  .stats_valid_o   (stats_valid_o)
);

### tb/fm_phase_discriminator_tb.sv
`timescale 1ns / 1ps

module fm_phase_discriminator_tb;

  localparam int unsigned STAGES = 16;
  localparam int unsigned ATAN_N = 24;
  localparam longint BLOCK_LEN_MAX = 8192;
  localparam longint SUM_CAP = 64'sd268435456;
  localparam longint SUM_MAX = (BLOCK_LEN_MAX * 32768 - 1 > SUM_CAP - 1) ?
                               SUM_CAP - 1 : BLOCK_LEN_MAX * 32768 - 1;
  localparam longint SUM_MIN = (-BLOCK_LEN_MAX * 32768 < -SUM_CAP) ?
                               -SUM_CAP : -BLOCK_LEN_MAX * 32768;
  localparam int WDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1350;
  localparam int QUIET_LEN = 200;
  localparam int HOLD_CYCLES = 150;
  localparam real PI = 3.14159265358979;

  typedef struct packed {
    logic signed [15:0] freq;
    logic signed [28:0] sum;
    logic [14:0]        pk_pos;
    logic signed [15:0] pk_neg;
    logic               valid;
  } result_t;

  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               last;
    logic               mute;
    logic               meas;
    logic               typed;
    result_t            res;
  } row_t;

  typedef enum logic [1:0] {SRC_NOISE, SRC_SMALL, SRC_EXTREME, SRC_TONE} src_kind_e;

  localparam result_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] s_i = '0;
  logic signed [15:0] s_q = '0;
  logic               s_last = 1'b0;
  logic               s_mute = 1'b0;
  logic               s_meas = 1'b0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic signed [15:0] freq_sample_o;
  logic signed [28:0] block_sum_o;
  logic [14:0]        peak_positive_o;
  logic signed [15:0] peak_negative_o;
  logic               stats_valid_o;

  fm_phase_discriminator #(
    .ANGLE_STAGES(STAGES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .i_sample_i     (s_i),
    .q_sample_i     (s_q),
    .last_in_block_i(s_last),
    .mute_i         (s_mute),
    .measure_i      (s_meas),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .freq_sample_o  (freq_sample_o),
    .block_sum_o    (block_sum_o),
    .peak_positive_o(peak_positive_o),
    .peak_negative_o(peak_negative_o),
    .stats_valid_o  (stats_valid_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // atan(2^-k) with pi = 2^31
  logic [31:0] atan_tab [0:ATAN_N-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // discriminator state as the block should hold it
  logic [15:0] last_ph = '0;
  longint      run_sum = 0;
  int          pk_hi = 0;
  int          pk_lo = 0;

  result_t pending_res [$];
  int      n_err = 0;
  int      n_results = 0;
  int      stall_cyc = 0;
  bit      quiet = 1'b0;
  bit      hold_armed = 1'b1;
  int      src_pct = 20;
  int      snk_pct = 20;
  int      snk_left = 0;
  logic [7:0] epoch_cnt = '0;

  real tone_ang = 0.0;
  real tone_step = 0.3;
  real tone_amp = 20000.0;

  function automatic logic [15:0] cordic_phase(input int x, input int y);
    logic [31:0] acc;
    int t;
    int dx;
    int dy;
    int k;
    acc = '0;
    if (x == 0 && y == 0) return 16'h0000;
    // fold the left half plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        acc = 32'h4000_0000;
      end else begin
        x = -y;
        y = t;
        acc = 32'hC000_0000;
      end
    end
    for (k = 0; k < STAGES && k < ATAN_N; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + atan_tab[k];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - atan_tab[k];
      end
    end
    acc = acc + 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic result_t discriminate(input logic signed [15:0] i, q,
                                           input logic last, mute, meas);
    logic [15:0] ph;
    int          f;
    longint      s;
    result_t     r;
    f = 0;
    if (mute) begin
      last_ph = '0;
    end else begin
      ph = cordic_phase(i, q);
      f = $signed(ph - last_ph);
      last_ph = ph;
    end
    if (meas) begin
      s = run_sum + f;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      run_sum = s;
      if (f > pk_hi) pk_hi = f;
      else if (f < pk_lo) pk_lo = f;
    end
    r = '0;
    r.freq = f[15:0];
    if (last && meas) begin
      r.sum = run_sum[28:0];
      r.pk_pos = pk_hi[14:0];
      r.pk_neg = pk_lo[15:0];
      r.valid = 1'b1;
    end
    if (last) begin
      run_sum = 0;
      pk_hi = 0;
      pk_lo = 0;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] extreme_val();
    case ($urandom_range(0, 6))
      0: return -16'sd32767 - 16'sd1;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic send(input logic signed [15:0] i, q, input logic last, mute, meas,
                      input logic typed, input result_t typed_res);
    int      gap;
    result_t r;
    if (!quiet && src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    s_i <= i;
    s_q <= q;
    s_last <= last;
    s_mute <= mute;
    s_meas <= meas;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    r = discriminate(i, q, last, mute, meas);
    pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic send_random(input src_kind_e kind, input logic last, mute, meas);
    logic signed [15:0] i;
    logic signed [15:0] q;
    case (kind)
      SRC_NOISE: begin
        i = 16'($urandom);
        q = 16'($urandom);
      end
      SRC_SMALL: begin
        i = 16'($urandom_range(0, 16)) - 16'sd8;
        q = 16'($urandom_range(0, 16)) - 16'sd8;
      end
      SRC_EXTREME: begin
        i = extreme_val();
        q = extreme_val();
      end
      default: begin
        tone_ang = tone_ang + tone_step;
        i = 16'($rtoi(tone_amp * $cos(tone_ang)));
        q = 16'($rtoi(tone_amp * $sin(tone_ang)));
      end
    endcase
    send(i, q, last, mute, meas, 1'b0, NO_CHECK);
  endtask

  row_t dir_tab [0:21] = '{
    '{0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}},         // zero sample right after reset
    '{32767, 0, 0, 0, 1, 0, NO_CHECK},
    '{-32768, 0, 0, 0, 1, 0, NO_CHECK},
    '{0, 32767, 0, 0, 1, 0, NO_CHECK},
    '{0, -32768, 0, 0, 1, 0, NO_CHECK},
    '{-32768, -32768, 0, 0, 1, 0, NO_CHECK},
    '{32767, 32767, 0, 0, 1, 0, NO_CHECK},
    '{-32768, 32767, 0, 0, 1, 0, NO_CHECK},
    '{32767, -32768, 1, 0, 1, 0, NO_CHECK},
    '{12345, -222, 0, 1, 1, 1, '{0, 0, 0, 0, 0}},   // squelch closed
    '{100, 200, 0, 0, 0, 0, NO_CHECK},
    '{-5, 7, 1, 1, 1, 1, '{0, 0, 0, 0, 1}},         // block of muted zeros only
    '{30000, 5000, 0, 0, 1, 0, NO_CHECK},
    '{-30000, 5000, 0, 0, 1, 0, NO_CHECK},
    '{1, -1, 1, 0, 0, 0, NO_CHECK},                 // block end without measurement
    '{0, 0, 1, 0, 1, 0, NO_CHECK},
    '{0, 0, 1, 1, 0, 1, '{0, 0, 0, 0, 0}},
    '{-1, -1, 0, 0, 1, 0, NO_CHECK},
    '{1, 0, 1, 0, 1, 0, NO_CHECK},
    '{0, 0, 1, 1, 1, 1, '{0, 0, 0, 0, 1}},
    '{-32768, 0, 0, 0, 1, 0, NO_CHECK},
    '{32767, 0, 1, 0, 1, 0, NO_CHECK}
  };

  initial begin : stim
    int          n;
    int          k;
    int          len;
    bit          paused;
    logic        blk_meas;
    logic        squelch;
    logic        noise;
    src_kind_e   kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      send(dir_tab[r].i, dir_tab[r].q, dir_tab[r].last, dir_tab[r].mute,
           dir_tab[r].meas, dir_tab[r].typed, dir_tab[r].res);
    end

    // blocks of random content, a few noise blocks with random framing
    n = 0;
    paused = 1'b0;
    while (n < N_RANDOM) begin
      if (!paused && n >= N_RANDOM / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_res.size() != 0);
      end
      // no idling on either side near the end
      if (n >= N_RANDOM - QUIET_LEN) quiet = 1'b1;
      kind = src_kind_e'($urandom_range(0, 3));
      len = $urandom_range(1, 24);
      blk_meas = ($urandom_range(0, 7) != 0);
      squelch = ($urandom_range(0, 9) == 0);
      noise = ($urandom_range(0, 6) == 0);
      tone_step = ($urandom_range(0, 2000) / 1000.0 - 1.0) * PI;
      tone_amp = $urandom_range(1, 32767);
      for (k = 0; k < len; k++) begin
        if (noise) begin
          send_random(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
          send_random(kind, k == len - 1, squelch || ($urandom_range(0, 15) == 0),
                      blk_meas ^ ($urandom_range(0, 15) == 0));
        end
        n++;
      end
    end
    in_valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (STAGES + 8) @(posedge clk);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // new idling rates each time the 8-bit epoch counter wraps, sometimes none at all
  always @(posedge clk) begin
    epoch_cnt <= epoch_cnt + 8'd1;
    if (epoch_cnt == 8'd0) begin
      src_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      snk_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    if (snk_left != 0) begin
      snk_left <= snk_left - 1;
      out_ready <= (snk_left == 1);
    end else if (!quiet && hold_armed && n_results >= 300) begin
      // long hold-off so the pipeline fills and backs up into the input
      hold_armed <= 1'b0;
      snk_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (!quiet && snk_pct != 0 && $urandom_range(0, 99) < snk_pct) begin
      snk_left <= $urandom_range(1, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      got = '{freq_sample_o, block_sum_o, peak_positive_o, peak_negative_o, stats_valid_o};
      n_results <= n_results + 1;
      if (pending_res.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected result: freq %0d sum %0d pk+ %0d pk- %0d stats %0b",
                   got.freq, got.sum, got.pk_pos, got.pk_neg, got.valid);
        end
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch at result %0d:", n_results);
            $display("  expected freq %0d sum %0d pk+ %0d pk- %0d stats %0b",
                     want.freq, want.sum, want.pk_pos, want.pk_neg, want.valid);
            $display("  actual   freq %0d sum %0d pk+ %0d pk- %0d stats %0b",
                     got.freq, got.sum, got.pk_pos, got.pk_neg, got.valid);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cyc <= 0;
    end else if (rst_n) begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc >= WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

### fm_phase_discriminator.f
design/fmpd_pkg.sv
design/fmpd_pre.sv
design/fmpd_cell.sv
design/fmpd_diff.sv
design/fmpd_stats.sv
design/fm_phase_discriminator.sv
design/fmpd_checker.sv
tb/fm_phase_discriminator_tb.sv
